// ----- rtl/core/wfc_pkg.sv -----
package wfc_pkg;

   localparam int WFC_TABLE_ENTRIES = 256;
   localparam int WFC_WORD_BYTES    = 32;

   localparam int WFC_BYTE_W   = 8;
   localparam int WFC_INDEX_W  = 8;
   localparam int WFC_COUNT_W  = 32;
   localparam int WFC_LENGTH_W = 6;

   localparam logic [WFC_COUNT_W-1:0] WFC_COUNT_MAX = '1;

   typedef logic [WFC_BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_TRUNC = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_SLOT,
      ST_CMP,
      ST_COUNT,
      ST_APPEND,
      ST_EMIT
   } state_type;

   function automatic logic wfc_is_space(byte_type b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic wfc_is_punct(byte_type b);
      return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
             (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
   endfunction

   function automatic byte_type wfc_fold(byte_type b);
      byte_type r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/wfc_req_if.sv -----
interface wfc_req_if import wfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WFC_BYTE_W-1:0] text_byte;
   logic                  end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

// ----- rtl/core/wfc_rsp_if.sv -----
interface wfc_rsp_if import wfc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [WFC_INDEX_W-1:0]  entry_index;
   logic [WFC_COUNT_W-1:0]  occurrence_count;
   logic                    is_new_word;
   logic [WFC_LENGTH_W-1:0] word_length;
   status_type              status;

   modport source (output valid, entry_index, occurrence_count, is_new_word, word_length,
                   status, input ready);
   modport sink   (input valid, entry_index, occurrence_count, is_new_word, word_length,
                   status, output ready);
endinterface

// ----- rtl/core/word_frequency_counter_core.sv -----
// channel   dir  beat payload                                              accepted when
// req_chan  in   text_byte, end_of_text                                   valid && ready
// rsp_chan  out  entry_index, occurrence_count, is_new_word, word_length,  valid && ready
//                status
//
// A byte that finishes no word is taken while ready stays high.
// A word end drops a trailing mark, then checks each stored slot in turn, moving on at a
// length mismatch and comparing bytes at a match; it then counts, appends, or drops when full.
// The byte compare reads and the append writes the character memory one byte a cycle.
// Reset clears the sequencer, the word in progress and the table fill count.
// A stalled result holds in the output register; the next word end waits only to load it.
module word_frequency_counter_core import wfc_pkg::*; #(
   parameter int TABLE_ENTRIES = WFC_TABLE_ENTRIES,
   parameter int WORD_BYTES    = WFC_WORD_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   wfc_req_if.sink   req_chan,
   wfc_rsp_if.source rsp_chan
);

   localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOTC_W = $clog2(TABLE_ENTRIES + 1);
   localparam int LEN_W   = $clog2(WORD_BYTES + 1);
   localparam int IDX_W   = $clog2(WORD_BYTES);
   localparam int CHAR_AW = $clog2(TABLE_ENTRIES * WORD_BYTES);

   state_type state_ff, state_in;

   byte_type               cur_word_ff [WORD_BYTES];
   logic [LEN_W-1:0]       cur_len_ff, cur_len_in;
   logic                   trunc_ff, trunc_in;
   logic [SLOTC_W-1:0]     used_ff, used_in;
   logic [SLOTC_W-1:0]     slot_ff, slot_in;
   logic [CHAR_AW-1:0]     base_ff, base_in;
   logic [LEN_W-1:0]       k_ff, k_in;
   logic [LEN_W-1:0]       len_eff_ff, len_eff_in;

   logic [SLOTC_W-1:0]     res_index_ff, res_index_in;
   logic [WFC_COUNT_W-1:0] res_count_ff, res_count_in;
   logic                   res_new_ff, res_new_in;
   status_type             res_status_ff, res_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WFC_INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [WFC_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                    rsp_new_ff, rsp_new_in;
   logic [WFC_LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                   req_ready;
   logic                   byte_space;
   logic                   store_byte;
   logic [IDX_W-1:0]       rd_idx;
   byte_type               rd_byte;

   logic                   char_we;
   logic [CHAR_AW-1:0]     char_waddr;
   logic [CHAR_AW-1:0]     char_raddr;
   byte_type               char_rdata;
   logic                   len_we;
   logic                   cnt_we;
   logic [WFC_COUNT_W-1:0] cnt_wdata;
   logic [LEN_W-1:0]       len_rdata;
   logic [WFC_COUNT_W-1:0] cnt_rdata;

   assign byte_space = wfc_is_space(req_chan.text_byte);
   assign rd_idx     = (state_ff == ST_TRIM) ? IDX_W'(cur_len_ff - 1'b1) : k_ff[IDX_W-1:0];
   assign rd_byte    = cur_word_ff[rd_idx];
   assign char_waddr = base_ff + CHAR_AW'(k_ff);
   assign char_raddr = base_in + CHAR_AW'(k_in);

   wfc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WORD_BYTES    (WORD_BYTES)
   ) u_table (
      .clock       (clock),
      .char_we     (char_we),
      .char_waddr  (char_waddr),
      .char_wdata  (rd_byte),
      .char_raddr  (char_raddr),
      .char_rdata  (char_rdata),
      .len_we      (len_we),
      .cnt_we      (cnt_we),
      .entry_waddr (slot_ff[SLOT_W-1:0]),
      .len_wdata   (len_eff_ff),
      .cnt_wdata   (cnt_wdata),
      .entry_raddr (slot_in[SLOT_W-1:0]),
      .len_rdata   (len_rdata),
      .cnt_rdata   (cnt_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cur_len_in    = cur_len_ff;
      trunc_in      = trunc_ff;
      used_in       = used_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      k_in          = k_ff;
      len_eff_in    = len_eff_ff;
      res_index_in  = res_index_ff;
      res_count_in  = res_count_ff;
      res_new_in    = res_new_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;
      store_byte    = 1'b0;
      char_we       = 1'b0;
      len_we        = 1'b0;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               if (!byte_space) begin
                  if (cur_len_ff < LEN_W'(WORD_BYTES)) begin
                     store_byte = 1'b1;
                     cur_len_in = cur_len_ff + 1'b1;
                  end else begin
                     trunc_in = 1'b1;
                  end
               end
               if ((byte_space || req_chan.end_of_text) && cur_len_in != '0) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            len_eff_in    = cur_len_ff - LEN_W'(wfc_is_punct(rd_byte));
            slot_in       = '0;
            base_in       = '0;
            k_in          = '0;
            res_status_in = trunc_ff ? STATUS_TRUNC : STATUS_OK;
            state_in      = ST_SLOT;
         end
         ST_SLOT: begin
            if (slot_ff == used_ff) begin
               if (used_ff < SLOTC_W'(TABLE_ENTRIES)) begin
                  state_in = ST_APPEND;
               end else begin
                  res_index_in  = '0;
                  res_count_in  = '0;
                  res_new_in    = 1'b0;
                  res_status_in = STATUS_FULL;
                  state_in      = ST_EMIT;
               end
            end else if (len_rdata != len_eff_ff) begin
               slot_in = slot_ff + 1'b1;
               base_in = base_ff + CHAR_AW'(WORD_BYTES);
            end else if (len_eff_ff == '0) begin
               state_in = ST_COUNT;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (char_rdata != rd_byte) begin
               slot_in  = slot_ff + 1'b1;
               base_in  = base_ff + CHAR_AW'(WORD_BYTES);
               k_in     = '0;
               state_in = ST_SLOT;
            end else if (k_ff + 1'b1 == len_eff_ff) begin
               state_in = ST_COUNT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_COUNT: begin
            cnt_we       = 1'b1;
            cnt_wdata    = (cnt_rdata == WFC_COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
            res_index_in = slot_ff;
            res_count_in = cnt_wdata;
            res_new_in   = 1'b0;
            state_in     = ST_EMIT;
         end
         ST_APPEND: begin
            if (k_ff == len_eff_ff) begin
               len_we       = 1'b1;
               cnt_we       = 1'b1;
               cnt_wdata    = WFC_COUNT_W'(1);
               used_in      = used_ff + 1'b1;
               res_index_in = slot_ff;
               res_count_in = WFC_COUNT_W'(1);
               res_new_in   = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               char_we = 1'b1;
               k_in    = k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = WFC_INDEX_W'(res_index_ff);
               rsp_count_in  = res_count_ff;
               rsp_new_in    = res_new_ff;
               rsp_len_in    = WFC_LENGTH_W'(len_eff_ff);
               rsp_status_in = res_status_ff;
               cur_len_in    = '0;
               trunc_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff   <= '0;
         trunc_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_len_ff   <= cur_len_in;
         trunc_ff     <= trunc_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         cur_word_ff[cur_len_ff[IDX_W-1:0]] <= wfc_fold(req_chan.text_byte);
      end
      slot_ff       <= slot_in;
      base_ff       <= base_in;
      k_ff          <= k_in;
      len_eff_ff    <= len_eff_in;
      res_index_ff  <= res_index_in;
      res_count_ff  <= res_count_in;
      res_new_ff    <= res_new_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.entry_index      = rsp_index_ff;
   assign rsp_chan.occurrence_count = rsp_count_ff;
   assign rsp_chan.is_new_word      = rsp_new_ff;
   assign rsp_chan.word_length      = rsp_len_ff;
   assign rsp_chan.status           = rsp_status_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOTC_W'(TABLE_ENTRIES))
      else $error("table fill count beyond table size");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= LEN_W'(WORD_BYTES))
      else $error("word length beyond word buffer");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_count_ff == '0 && !rsp_new_ff)
      else $error("dropped word reports a count");

   a_new_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_new_ff |-> rsp_count_ff == WFC_COUNT_W'(1) &&
                                     rsp_status_ff != STATUS_FULL)
      else $error("new word with wrong count or status");

   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPEND && k_ff == len_eff_ff |=> used_ff == $past(used_ff) + 1'b1)
      else $error("append did not advance fill count");

endmodule

// ----- rtl/core/wfc_table.sv -----
module wfc_table import wfc_pkg::*; #(
   parameter int TABLE_ENTRIES = WFC_TABLE_ENTRIES,
   parameter int WORD_BYTES    = WFC_WORD_BYTES,
   localparam int SLOT_W  = $clog2(TABLE_ENTRIES),
   localparam int LEN_W   = $clog2(WORD_BYTES + 1),
   localparam int CHAR_AW = $clog2(TABLE_ENTRIES * WORD_BYTES)
) (
   input  logic                   clock,
   input  logic                   char_we,
   input  logic [CHAR_AW-1:0]     char_waddr,
   input  byte_type               char_wdata,
   input  logic [CHAR_AW-1:0]     char_raddr,
   output byte_type               char_rdata,
   input  logic                   len_we,
   input  logic                   cnt_we,
   input  logic [SLOT_W-1:0]      entry_waddr,
   input  logic [LEN_W-1:0]       len_wdata,
   input  logic [WFC_COUNT_W-1:0] cnt_wdata,
   input  logic [SLOT_W-1:0]      entry_raddr,
   output logic [LEN_W-1:0]       len_rdata,
   output logic [WFC_COUNT_W-1:0] cnt_rdata
);

   byte_type               char_mem [TABLE_ENTRIES*WORD_BYTES];
   logic [LEN_W-1:0]       len_mem  [TABLE_ENTRIES];
   logic [WFC_COUNT_W-1:0] cnt_mem  [TABLE_ENTRIES];

   byte_type               char_rdata_ff;
   logic [LEN_W-1:0]       len_rdata_ff;
   logic [WFC_COUNT_W-1:0] cnt_rdata_ff;

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_waddr] <= char_wdata;
      end
      char_rdata_ff <= char_mem[char_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[entry_waddr] <= len_wdata;
      end
      len_rdata_ff <= len_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[entry_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[entry_raddr];
   end

   assign char_rdata = char_rdata_ff;
   assign len_rdata  = len_rdata_ff;
   assign cnt_rdata  = cnt_rdata_ff;

endmodule

// ----- dv/wfc_tally_checker.sv -----
`timescale 1ns / 100ps

module wfc_tally_checker import wfc_pkg::*; (
   input  logic clock,
   input  logic reset,
   wfc_req_if   req_mon,
   wfc_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending,
   output int   words_checked,
   output int   words_new,
   output int   words_dropped,
   output int   words_truncated
);

   typedef struct {
      logic [WFC_INDEX_W-1:0]  index;
      logic [WFC_COUNT_W-1:0]  count;
      logic                    is_new;
      logic [WFC_LENGTH_W-1:0] length;
      status_type              status;
   } tally_t;

   tally_t tally_q[$];

   byte_type               word_buf   [WFC_WORD_BYTES];
   int unsigned            word_len;
   bit                     word_trunc;
   byte_type               slot_chars [WFC_TABLE_ENTRIES][WFC_WORD_BYTES];
   int unsigned            slot_len   [WFC_TABLE_ENTRIES];
   logic [WFC_COUNT_W-1:0] slot_count [WFC_TABLE_ENTRIES];
   int unsigned            slots_used;

   function automatic bit is_blank(byte_type b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit is_mark(byte_type b);
      return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
             (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
   endfunction

   function automatic bit slot_equal(int unsigned s, int unsigned n);
      int unsigned k;
      if (slot_len[s] != n) begin
         return 1'b0;
      end
      for (k = 0; k < n; k++) begin
         if (slot_chars[s][k] != word_buf[k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ERROR %s", $time, msg);
      end
   endtask

   task automatic close_word();
      int unsigned n;
      int unsigned s;
      int unsigned k;
      bit          hit;
      tally_t      t;
      n = word_len;
      if (n > 0 && is_mark(word_buf[n-1])) begin
         n--;
      end
      t.index  = '0;
      t.count  = '0;
      t.is_new = 1'b0;
      t.status = word_trunc ? STATUS_TRUNC : STATUS_OK;
      hit = 1'b0;
      for (s = 0; s < slots_used; s++) begin
         if (slot_equal(s, n)) begin
            hit = 1'b1;
            break;
         end
      end
      if (hit) begin
         if (slot_count[s] != WFC_COUNT_MAX) begin
            slot_count[s]++;
         end
         t.count = slot_count[s];
         t.index = s[WFC_INDEX_W-1:0];
      end else if (slots_used < WFC_TABLE_ENTRIES) begin
         s = slots_used;
         for (k = 0; k < n; k++) begin
            slot_chars[s][k] = word_buf[k];
         end
         slot_len[s]   = n;
         slot_count[s] = 1;
         slots_used++;
         t.count  = 1;
         t.index  = s[WFC_INDEX_W-1:0];
         t.is_new = 1'b1;
      end else begin
         t.status = STATUS_FULL;
      end
      t.length = n[WFC_LENGTH_W-1:0];
      tally_q.push_back(t);
      word_len   = 0;
      word_trunc = 1'b0;
   endtask

   task automatic take_byte(byte_type b, logic eot);
      byte_type c;
      bit       closed;
      closed = 1'b0;
      if (is_blank(b)) begin
         if (word_len > 0) begin
            close_word();
            closed = 1'b1;
         end
      end else begin
         c = b;
         if (c >= 8'h41 && c <= 8'h5A) begin
            c = c + 8'h20;
         end
         if (word_len < WFC_WORD_BYTES) begin
            word_buf[word_len] = c;
            word_len++;
         end else begin
            word_trunc = 1'b1;
         end
      end
      if (eot && !closed && word_len > 0) begin
         close_word();
      end
   endtask

   task automatic check_result();
      tally_t want;
      if (tally_q.size() == 0) begin
         report_mismatch($sformatf("result with no word pending: index %0d count %0d",
                                   rsp_mon.entry_index, rsp_mon.occurrence_count));
         return;
      end
      want = tally_q.pop_front();
      words_checked++;
      if (rsp_mon.entry_index !== want.index) begin
         report_mismatch($sformatf("word %0d: entry_index %0d, want %0d",
                                   words_checked, rsp_mon.entry_index, want.index));
      end
      if (rsp_mon.occurrence_count !== want.count) begin
         report_mismatch($sformatf("word %0d: occurrence_count %0d, want %0d",
                                   words_checked, rsp_mon.occurrence_count, want.count));
      end
      if (rsp_mon.is_new_word !== want.is_new) begin
         report_mismatch($sformatf("word %0d: is_new_word %b, want %b",
                                   words_checked, rsp_mon.is_new_word, want.is_new));
      end
      if (rsp_mon.word_length !== want.length) begin
         report_mismatch($sformatf("word %0d: word_length %0d, want %0d",
                                   words_checked, rsp_mon.word_length, want.length));
      end
      if (rsp_mon.status !== want.status) begin
         report_mismatch($sformatf("word %0d: status %0d, want %0d",
                                   words_checked, rsp_mon.status, want.status));
      end
      if (want.is_new) begin
         words_new++;
      end
      if (want.status == STATUS_FULL) begin
         words_dropped++;
      end
      if (want.status == STATUS_TRUNC) begin
         words_truncated++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         word_len   = 0;
         word_trunc = 1'b0;
         slots_used = 0;
         tally_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
         if (req_mon.valid && req_mon.ready) begin
            take_byte(req_mon.text_byte, req_mon.end_of_text);
         end
      end
      pending = tally_q.size();
   end

endmodule

// ----- dv/tb_word_frequency_counter_core.sv -----
`timescale 1ns / 100ps

module tb_word_frequency_counter_core;
   import wfc_pkg::*;

   localparam int HIST = 128;
   localparam int MAXW = 48;

   logic clock;
   logic reset;

   wfc_req_if req_chan ();
   wfc_rsp_if rsp_chan ();

   int mismatches;
   int pending_words;
   int words_checked;
   int words_new;
   int words_dropped;
   int words_truncated;

   int bytes_sent;
   int send_idle_pct;
   int take_idle_pct;
   bit hold_rsp;

   byte_type wbuf      [MAXW];
   byte_type hist_bytes[HIST][MAXW];
   int       hist_len  [HIST];
   int       hist_n;

   word_frequency_counter_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wfc_tally_checker i_tally (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatches      (mismatches),
      .pending         (pending_words),
      .words_checked   (words_checked),
      .words_new       (words_new),
      .words_dropped   (words_dropped),
      .words_truncated (words_truncated)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic byte_type pick_blank();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? 8'h20 : byte_type'(8'h09 + k);
   endfunction

   function automatic byte_type pick_mark();
      int k;
      k = $urandom_range(31);
      if (k < 15) begin
         return byte_type'(8'h21 + k);
      end else if (k < 22) begin
         return byte_type'(8'h3A + k - 15);
      end else if (k < 28) begin
         return byte_type'(8'h5B + k - 22);
      end
      return byte_type'(8'h7B + k - 28);
   endfunction

   function automatic byte_type pick_letter();
      byte_type c;
      c = byte_type'(8'h61 + $urandom_range(25));
      if ($urandom_range(2) == 0) begin
         c = c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic byte_type pick_solid();
      byte_type b;
      b = byte_type'($urandom_range(255));
      while ((b == 8'h20) || (b >= 8'h09 && b <= 8'h0D)) begin
         b = byte_type'($urandom_range(255));
      end
      return b;
   endfunction

   // hold the beat until accepted, then advance to the next falling edge
   task automatic send_beat(byte_type b, logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      bytes_sent++;
      if (bytes_sent < 370) begin
         send_idle_pct = 21;
         take_idle_pct = 63;
      end else if (bytes_sent < 740) begin
         send_idle_pct = 63;
         take_idle_pct = 21;
      end else begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end
   endtask

   task automatic send_text(string s, bit eot_last);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_beat(byte_type'(s[i]), eot_last && (i == s.len() - 1));
      end
   endtask

   task automatic send_word(int n);
      int t;
      int k;
      t = $urandom_range(19);
      for (k = 0; k < n; k++) begin
         send_beat(wbuf[k], (t == 0) && (k == n - 1));
      end
      if (t != 0) begin
         send_beat(pick_blank(), t == 1);
         if (t == 2) begin
            send_beat(pick_blank(), 1'b0);
         end
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            hold_rsp = 1'b0;
            repeat (500) @(negedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   initial begin
      #100_000_000;
      $display("timeout with %0d words pending", pending_words);
      $display("tb_word_frequency_counter_core NOT OK");
      $finish;
   end

   initial begin
      int       r;
      int       n;
      int       k;
      int       h;
      bit       hold_done;
      bit       pause_done;
      byte_type b;

      req_chan.valid       = 1'b0;
      req_chan.text_byte   = '0;
      req_chan.end_of_text = 1'b0;
      reset                = 1'b1;
      hold_rsp             = 1'b0;
      hold_done            = 1'b0;
      pause_done           = 1'b0;
      bytes_sent           = 0;
      hist_n               = 0;
      send_idle_pct        = 21;
      take_idle_pct        = 63;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("Ab! ", 1'b0);
      send_text("aB. ", 1'b0);
      send_text("? ", 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h0D, 1'b0);
      send_text("~", 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'h20, 1'b1);
      send_beat(8'h09, 1'b1);
      send_text("Z", 1'b1);
      send_text("!! ", 1'b0);
      send_beat(8'h0B, 1'b0);
      send_beat(8'h0C, 1'b0);
      send_beat(8'h0A, 1'b0);

      while (bytes_sent < 1100) begin
         if (!hold_done && bytes_sent >= 400) begin
            hold_rsp  = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && bytes_sent >= 750) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
            while (pending_words != 0) begin
               @(negedge clock);
            end
            pause_done = 1'b1;
         end
         r = $urandom_range(99);
         if (r >= 86) begin
            n = $urandom_range(4, 1);
            for (k = 0; k < n; k++) begin
               send_beat(byte_type'($urandom_range(255)), $urandom_range(9) == 0);
            end
            continue;
         end
         if (r < 45) begin
            n = $urandom_range(4, 1);
            for (k = 0; k < n; k++) begin
               wbuf[k] = pick_letter();
            end
            if ($urandom_range(3) == 0) begin
               wbuf[n] = pick_mark();
               n++;
            end
         end else if (r < 65 && hist_n > 0) begin
            h = $urandom_range(((hist_n < HIST) ? hist_n : HIST) - 1);
            n = hist_len[h];
            for (k = 0; k < n; k++) begin
               b = hist_bytes[h][k];
               if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
                   $urandom_range(1) == 1) begin
                  b = b ^ 8'h20;
               end
               wbuf[k] = b;
            end
         end else if (r < 75) begin
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) begin
               wbuf[k] = pick_solid();
            end
         end else if (r < 79) begin
            n = $urandom_range(40, 31);
            for (k = 0; k < n; k++) begin
               wbuf[k] = byte_type'(8'h61 + $urandom_range(3));
            end
            if ($urandom_range(1) == 1) begin
               wbuf[WFC_WORD_BYTES-1] = pick_mark();
            end
         end else begin
            n = 1;
            wbuf[0] = pick_mark();
         end
         h = hist_n % HIST;
         hist_len[h] = n;
         for (k = 0; k < n; k++) begin
            hist_bytes[h][k] = wbuf[k];
         end
         hist_n++;
         send_word(n);
      end

      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);

      $display("sent %0d text bytes; checked %0d finished words", bytes_sent, words_checked);
      $display("  %0d added to the table, %0d dropped while full, %0d cut to %0d bytes",
               words_new, words_dropped, words_truncated, WFC_WORD_BYTES);
      if (mismatches == 0 && pending_words == 0) begin
         $display("tb_word_frequency_counter_core OK");
      end else begin
         $display("tb_word_frequency_counter_core NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/wfc_pkg.sv
rtl/core/wfc_req_if.sv
rtl/core/wfc_rsp_if.sv
rtl/core/wfc_table.sv
rtl/core/word_frequency_counter_core.sv
dv/wfc_tally_checker.sv
dv/tb_word_frequency_counter_core.sv
